>>> design/bsr_pkg.sv
// Shared types and constants for the byte stream reassembler.
`timescale 1ns / 1ps
package bsr_pkg;

   localparam int BYTE_W = 8;
   localparam int POS_W  = 32;
   localparam int END_W  = 33;
   localparam int USED_W = 7;
   localparam int PEND_W = 7;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;

   localparam logic [END_W-1:0] END_UNKNOWN = {END_W{1'b1}};
   localparam logic [END_W-1:0] POS_LIMIT   = {1'b0, {POS_W{1'b1}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SCAN,
      ST_SETTLE,
      ST_STATUS,
      ST_READ,
      ST_LOAD
   } bsr_state_type;

   typedef struct packed {
      logic capture;
      logic eval;
      logic scan_step;
      logic settle;
      logic read;
      logic load_byte;
      logic load_status;
   } bsr_cmd_type;

   typedef struct packed {
      logic scan_hit;
      logic count_zero;
      logic remaining_one;
      logic out_free;
   } bsr_status_type;

endpackage

>>> design/bsr_controller.sv
// Sequencing state machine for the byte stream reassembler.
`timescale 1ns / 1ps
module bsr_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  bsr_pkg::bsr_status_type status,
   output bsr_pkg::bsr_cmd_type    cmd
);
   import bsr_pkg::*;

   bsr_state_type state_ff;
   bsr_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (!status.scan_hit) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            cmd.settle = 1'b1;
            state_in   = status.count_zero ? ST_STATUS : ST_READ;
         end
         ST_STATUS: begin
            if (status.out_free) begin
               cmd.load_status = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.load_byte = 1'b1;
               state_in      = status.remaining_one ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> design/bsr_datapath.sv
// Slot ring, stream position registers and result register.
`timescale 1ns / 1ps
module bsr_datapath #(
   parameter int CAPACITY = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [bsr_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tuser,
   input  logic                             req_tlast,
   input  bsr_pkg::bsr_cmd_type             cmd,
   output bsr_pkg::bsr_status_type          status,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bsr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast
);
   import bsr_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // captured transaction
   logic [BYTE_W-1:0] data_ff;
   logic [POS_W-1:0]  pos_ff;
   logic              present_ff;
   logic              eof_ff;
   logic [USED_W-1:0] used_ff;
   logic              in_window_ff;

   // stream state
   logic [CAPACITY-1:0] filled_ff;
   logic [POS_W-1:0]    next_ff;
   logic [IDX_W-1:0]    next_slot_ff;
   logic [END_W-1:0]    end_ff;
   logic [PEND_W-1:0]   pending_ff;
   logic                finished_ff;
   logic [IDX_W-1:0]    scan_ff;
   logic [CNT_W-1:0]    count_ff;

   logic [BYTE_W-1:0] slot_mem [CAPACITY];
   logic [BYTE_W-1:0] rd_ff;

   // result register
   logic              ovalid_ff;
   logic [BYTE_W-1:0] obyte_ff;
   logic              obit_ff;
   logic              olast_ff;
   logic              odone_ff;
   logic [PEND_W-1:0] opend_ff;

   logic [END_W-1:0]   next_ext;
   logic [END_W-1:0]   pos_ext;
   logic               in_window;
   logic [USED_W-1:0]  room;
   logic [END_W-1:0]   room_top;
   logic [END_W-1:0]   limit;
   logic [IDX_W-1:0]   offset;
   logic [IDX_W:0]     slot_sum;
   logic [IDX_W:0]     slot_wrap;
   logic               slot_ok;
   logic [IDX_W-1:0]   slot;
   logic               slot_taken;
   logic               write_ok;
   logic [END_W-1:0]   end_cand;
   logic [END_W-1:0]   next_sum;
   logic               scan_hit;
   logic               out_free;

   always_comb begin
      next_ext  = {1'b0, next_ff};
      pos_ext   = {1'b0, pos_ff};
      in_window = pos_ext < (next_ext + END_W'(CAPACITY));
      room      = (used_ff >= USED_W'(CAPACITY)) ? '0 : (USED_W'(CAPACITY) - used_ff);
      room_top  = next_ext + END_W'(room);
      limit     = (end_ff < room_top) ? end_ff : room_top;
      limit     = (limit < POS_LIMIT) ? limit : POS_LIMIT;
      offset    = IDX_W'(pos_ff - next_ff);
      slot_sum  = {1'b0, next_slot_ff} + {1'b0, offset};
      slot_wrap = (slot_sum >= (IDX_W+1)'(CAPACITY)) ? slot_sum - (IDX_W+1)'(CAPACITY)
                                                      : slot_sum;
      slot_ok   = slot_wrap < (IDX_W+1)'(CAPACITY);
      slot      = slot_wrap[IDX_W-1:0];
      slot_taken = slot_ok ? filled_ff[slot] : 1'b1;
      write_ok  = in_window && present_ff && (pos_ext >= next_ext) && (pos_ext < limit)
                  && !slot_taken;
      end_cand  = pos_ext + END_W'(present_ff);
      next_sum  = next_ext + END_W'(count_ff);
      scan_hit  = filled_ff[scan_ff] && (count_ff != CNT_W'(CAPACITY));
      out_free  = !ovalid_ff || rsp_tready;
   end

   assign status.scan_hit      = scan_hit;
   assign status.count_zero    = (count_ff == '0);
   assign status.remaining_one = (count_ff == CNT_W'(1));
   assign status.out_free      = out_free;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         data_ff    <= req_tdata[7:0];
         pos_ff     <= req_tdata[39:8];
         used_ff    <= req_tdata[46:40];
         present_ff <= req_tuser;
         eof_ff     <= req_tlast;
      end
      if (cmd.eval) begin
         in_window_ff <= in_window;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval && write_ok) begin
         slot_mem[slot] <= data_ff;
      end
      if (cmd.read) begin
         rd_ff <= slot_mem[next_slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff    <= '0;
         next_ff      <= '0;
         next_slot_ff <= '0;
         end_ff       <= END_UNKNOWN;
         pending_ff   <= '0;
         finished_ff  <= 1'b0;
         scan_ff      <= '0;
         count_ff     <= '0;
      end else begin
         if (cmd.eval) begin
            scan_ff  <= next_slot_ff;
            count_ff <= '0;
            if (in_window && eof_ff && (end_cand < end_ff)) begin
               end_ff <= end_cand;
            end
            if (write_ok) begin
               filled_ff[slot] <= 1'b1;
               pending_ff      <= pending_ff + PEND_W'(1);
            end
         end
         if (cmd.scan_step && scan_hit) begin
            count_ff <= count_ff + CNT_W'(1);
            scan_ff  <= (scan_ff == IDX_W'(CAPACITY - 1)) ? '0 : scan_ff + IDX_W'(1);
         end
         if (cmd.settle) begin
            next_ff    <= next_sum[POS_W-1:0];
            pending_ff <= pending_ff - PEND_W'(count_ff);
            if (in_window_ff && (next_sum == end_ff)) begin
               finished_ff <= 1'b1;
            end
         end
         if (cmd.load_byte) begin
            filled_ff[next_slot_ff] <= 1'b0;
            next_slot_ff <= (next_slot_ff == IDX_W'(CAPACITY - 1)) ? '0
                            : next_slot_ff + IDX_W'(1);
            count_ff     <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (cmd.load_byte || cmd.load_status) begin
         ovalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         ovalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_byte || cmd.load_status) begin
         obyte_ff <= cmd.load_byte ? rd_ff : '0;
         obit_ff  <= cmd.load_byte;
         olast_ff <= cmd.load_status || (count_ff == CNT_W'(1));
         odone_ff <= finished_ff;
         opend_ff <= pending_ff;
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {6'd0, (opend_ff == '0), opend_ff, odone_ff, obit_ff, obyte_ff};

endmodule

>>> design/byte_stream_reassembler.sv
// Top level of the byte stream reassembler.
//
// Input channel req_*: one stream byte per transaction with its absolute
// position, the number of bytes still held downstream, a byte-present flag
// on req_tuser and an end-of-stream mark on req_tlast. The byte is stored
// in a ring of CAPACITY slots when present, in the receive window, slot empty.
// Result channel rsp_*: every contiguous byte from the next expected
// position is released in order, one transaction each; a transaction that
// releases nothing returns one status result. rsp_tlast marks the final
// result of each input transaction; status fields show the state after it.
// Sequence: a transaction is accepted, its byte stored, the filled flags
// scanned (one flag per cycle) and the next position settled; then each
// released byte is read through the registered slot memory port and loaded,
// or one status result is loaded. One transaction is in work at a time.
// Reset clears all slot flags, the next position, counts and result valid;
// no clearing pass is needed. A stalled receiver holds the result register
// and the drain waits; the last result may wait while the next input
// transaction is taken.
`timescale 1ns / 1ps
module byte_stream_reassembler #(
   parameter int CAPACITY = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [bsr_pkg::REQ_DATA_W-1:0] req_tdata,  // data_byte, position, output_used, zero pad
   input  logic                           req_tuser,  // byte_present
   input  logic                           req_tlast,  // ends_stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [bsr_pkg::RSP_DATA_W-1:0] rsp_tdata,  // out_byte, out_valid, stream_done,
                                                      // pending_count, none_pending, zero pad
   output logic                           rsp_tlast   // last_of_run
);
   import bsr_pkg::*;

   bsr_cmd_type    cmd;
   bsr_status_type status;

   bsr_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bsr_datapath #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> design/bsr_checker.sv
// Port-level assertions for the byte stream reassembler, bound to the top level.
`timescale 1ns / 1ps
module bsr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [bsr_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                           req_tuser,
   input logic                           req_tlast,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [bsr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast
);
   import bsr_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_none_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[17] == (rsp_tdata[16:10] == 7'd0)))
      else $error("none_pending disagrees with pending_count");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[8] |-> rsp_tlast && (rsp_tdata[7:0] == 8'd0))
      else $error("status result not last or carries a byte");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transaction taken while one is in work");

endmodule

bind byte_stream_reassembler bsr_checker u_bsr_checker (.*);
